// ----- rtl/core/lssk_pkg.sv -----
package lssk_pkg;

    // Fixed field widths of the words on the ports.
    localparam int ELEMENT_BITS = 16;
    localparam int TARGET_BITS  = 23;
    localparam int START_BITS   = 7;
    localparam int END_BITS     = 7;
    localparam int LENGTH_BITS  = 8;

    localparam int DEF_MAX_ELEMENTS = 128;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] element_value;
        logic                           last_element;
    } elem_word_t;

    typedef struct packed {
        logic                   found;
        logic [START_BITS-1:0]  start_index;
        logic [END_BITS-1:0]    end_index;
        logic [LENGTH_BITS-1:0] match_length;
    } res_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEED,
        ST_SEARCH,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_need;
        logic search;
        logic update;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic last;
        logic search_done;
        logic out_busy;
    } status_t;

endpackage

// ----- rtl/core/lssk_ram.sv -----
module lssk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/lssk_ctrl.sv -----
module lssk_ctrl
    import lssk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    elem_valid,
    output logic    elem_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (elem_valid)
                begin
                    state_next = ST_NEED;
                end
            end
            ST_NEED:
            begin
                // An element beyond the capacity is dropped, but its flag still counts.
                priority if (!status.full)
                begin
                    state_next = ST_SEARCH;
                end
                else if (status.last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = status.last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        elem_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                elem_ready = 1'b1;
                cmd.accept = elem_valid;
            end
            ST_NEED:
            begin
                cmd.load_need = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/lssk_dp.sv -----
module lssk_dp
    import lssk_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic signed [TARGET_BITS-1:0] cfg_data,
    input  elem_word_t                    elem,
    output logic                          res_valid,
    input  logic                          res_ready,
    output res_word_t                     res,
    input  cmd_t                          cmd,
    output status_t                       status
);

    localparam int IDX_BITS    = $clog2(MAX_ELEMENTS);
    localparam int CNT_BITS    = $clog2(MAX_ELEMENTS + 1);
    localparam int PREFIX_BITS = ELEMENT_BITS + IDX_BITS;
    localparam int CMP_BITS    =
        ((PREFIX_BITS > TARGET_BITS) ? PREFIX_BITS : TARGET_BITS) + 1;

    logic signed [TARGET_BITS-1:0] target_reg;
    logic signed [PREFIX_BITS-1:0] prefix_reg;
    logic [CNT_BITS-1:0]           count_reg;
    logic                          last_reg;
    logic signed [CMP_BITS-1:0]    need_reg;
    logic [CNT_BITS-1:0]           srch_addr_reg;
    logic                          pend_reg;
    logic [IDX_BITS-1:0]           pend_addr_reg;
    logic                          hit_reg;
    logic [CNT_BITS-1:0]           from_reg;
    logic [IDX_BITS-1:0]           best_start_reg;
    logic [IDX_BITS-1:0]           best_end_reg;
    logic [CNT_BITS-1:0]           best_length_reg;
    logic                          res_valid_reg;
    res_word_t                     res_reg;

    logic [PREFIX_BITS-1:0]        rd_data;
    logic signed [CMP_BITS-1:0]    stored_ext;
    logic signed [CMP_BITS-1:0]    need_next;
    logic                          need_zero;
    logic                          match;
    logic                          issue;
    logic                          full;
    logic [CNT_BITS-1:0]           len;

    assign full = (count_reg == CNT_BITS'(MAX_ELEMENTS));

    // The difference is taken one bit wider than either operand, so it never wraps.
    assign need_next =
        {{(CMP_BITS-PREFIX_BITS){prefix_reg[PREFIX_BITS-1]}}, prefix_reg}
      - {{(CMP_BITS-TARGET_BITS){target_reg[TARGET_BITS-1]}}, target_reg};

    assign stored_ext = {{(CMP_BITS-PREFIX_BITS){rd_data[PREFIX_BITS-1]}}, rd_data};
    assign need_zero  = (need_reg == '0);
    assign match      = pend_reg && (stored_ext == need_reg);
    assign issue      = !need_zero && !match && (srch_addr_reg < count_reg);
    assign len        = count_reg + CNT_BITS'(1) - from_reg;

    assign status.full        = full;
    assign status.last        = last_reg;
    assign status.search_done = need_zero || match || (!pend_reg && (srch_addr_reg == count_reg));
    assign status.out_busy    = res_valid_reg && !res_ready;

    lssk_ram #(
        .WIDTH (PREFIX_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (count_reg[IDX_BITS-1:0]),
        .wr_data (prefix_reg),
        .rd_en   (cmd.search && issue),
        .rd_addr (srch_addr_reg[IDX_BITS-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    // Per-array state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg      <= '0;
            count_reg       <= '0;
            best_start_reg  <= '0;
            best_end_reg    <= '0;
            best_length_reg <= '0;
        end
        else if (cmd.emit)
        begin
            prefix_reg      <= '0;
            count_reg       <= '0;
            best_start_reg  <= '0;
            best_end_reg    <= '0;
            best_length_reg <= '0;
        end
        else if (cmd.accept && !full)
        begin
            prefix_reg <= prefix_reg
                        + {{(PREFIX_BITS-ELEMENT_BITS){elem.element_value[ELEMENT_BITS-1]}},
                           elem.element_value};
        end
        else if (cmd.update)
        begin
            count_reg <= count_reg + CNT_BITS'(1);
            // Strictly longer only, so a tie keeps the earlier subarray.
            if (hit_reg && (len > best_length_reg))
            begin
                best_start_reg  <= from_reg[IDX_BITS-1:0];
                best_end_reg    <= count_reg[IDX_BITS-1:0];
                best_length_reg <= len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg <= elem.last_element;
            end
            if (cmd.load_need)
            begin
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            else if (cmd.search)
            begin
                pend_reg <= issue;
                if (need_zero || match)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Search datapath: one read issued per cycle, compared when its data returns.
    always_ff @(posedge clk)
    begin
        if (cmd.load_need)
        begin
            need_reg      <= need_next;
            srch_addr_reg <= '0;
            from_reg      <= '0;
        end
        else if (cmd.search)
        begin
            pend_addr_reg <= srch_addr_reg[IDX_BITS-1:0];
            if (issue)
            begin
                srch_addr_reg <= srch_addr_reg + CNT_BITS'(1);
            end
            priority if (need_zero)
            begin
                from_reg <= '0;
            end
            else if (match)
            begin
                from_reg <= CNT_BITS'(pend_addr_reg) + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.found        <= (best_length_reg != '0);
            res_reg.start_index  <= START_BITS'(best_start_reg);
            res_reg.end_index    <= END_BITS'(best_end_reg);
            res_reg.match_length <= LENGTH_BITS'(best_length_reg);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/core/longest_subarray_with_sum_k.sv -----
// Longest subarray whose elements sum to a programmable target.
// Elements enter one word at a time on the elem channel (valid/ready); the
// word marked last_element ends the array. One result word leaves on the res
// channel (valid/ready) for each array: found, start and end index, length.
// The target is written on the cfg channel, which is always ready; write it
// only while the block is idle. Reset sets the target to zero and clears the
// array state.
// An element with index i is handled in steps: it is accepted, the needed
// prefix is formed, the prefix store is scanned through the single read port
// one stored prefix per cycle (i reads, each compared once its registered data
// returns, ending early on the first hit), and the new prefix is written. A
// last element then waits until the result register is free and loads it.
// The result register lets a new array start while a result is pending; only
// the next last element waits until the receiver has taken that result.
// Elements beyond MAX_ELEMENTS are dropped, but their last flag is honored.
module longest_subarray_with_sum_k
    import lssk_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic signed [TARGET_BITS-1:0] cfg_data,
    input  logic                          elem_valid,
    output logic                          elem_ready,
    input  elem_word_t                    elem,
    output logic                          res_valid,
    input  logic                          res_ready,
    output res_word_t                     res
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lssk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .status     (status),
        .cmd        (cmd)
    );

    lssk_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .elem      (elem),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- tb/lssk_checker.sv -----
`timescale 1ns / 100ps

module lssk_checker
    import lssk_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic signed [TARGET_BITS-1:0] cfg_data,
    input  logic                          elem_valid,
    input  logic                          elem_ready,
    input  elem_word_t                    elem,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  res_word_t                     res,
    output int                            failures,
    output int                            outstanding
);

    logic signed [TARGET_BITS-1:0] target_sum;
    longint                        running_sum;
    int                            held_count;
    longint                        prefix_mem [MAX_ELEMENTS];
    int                            best_from;
    int                            best_to;
    int                            best_len;
    res_word_t                     expected_results [$];
    int                            fail_total = 0;

    task automatic clear_array();
        running_sum = 0;
        held_count  = 0;
        best_from   = 0;
        best_to     = 0;
        best_len    = 0;
    endtask

    task automatic log_failure(input string what);
        fail_total++;
        if (fail_total <= 10)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Folds one accepted element word into the running search and queues the
    // result word when the array ends.
    task automatic fold_element(input elem_word_t w);
        longint    need;
        int        from;
        bit        hit;
        res_word_t r;
        if (held_count < MAX_ELEMENTS)
        begin
            running_sum += longint'($signed(w.element_value));
            need = running_sum - longint'(target_sum);
            hit  = (need == 0);
            from = 0;
            // The empty prefix is tried first, then the earliest stored prefix.
            for (int j = 0; j < held_count && !hit; j++)
            begin
                if (prefix_mem[j] == need)
                begin
                    hit  = 1'b1;
                    from = j + 1;
                end
            end
            // Strictly longer only, so a tie keeps the earlier subarray.
            if (hit && (held_count + 1 - from) > best_len)
            begin
                best_from = from;
                best_to   = held_count;
                best_len  = held_count + 1 - from;
            end
            prefix_mem[held_count] = running_sum;
            held_count++;
        end
        if (w.last_element)
        begin
            r.found        = (best_len != 0);
            r.start_index  = START_BITS'(best_from);
            r.end_index    = END_BITS'(best_to);
            r.match_length = LENGTH_BITS'(best_len);
            expected_results.push_back(r);
            clear_array();
        end
    endtask

    task automatic check_result(input res_word_t got);
        res_word_t want;
        if (expected_results.size() == 0)
        begin
            log_failure($sformatf("unexpected result word: found=%0d start=%0d end=%0d len=%0d",
                                  got.found, got.start_index, got.end_index,
                                  got.match_length));
            return;
        end
        want = expected_results.pop_front();
        if (got.found !== want.found || got.start_index !== want.start_index ||
            got.end_index !== want.end_index || got.match_length !== want.match_length)
        begin
            log_failure($sformatf({"mismatch: expected found=%0d start=%0d end=%0d len=%0d,",
                                   " got found=%0d start=%0d end=%0d len=%0d"},
                                  want.found, want.start_index, want.end_index,
                                  want.match_length, got.found, got.start_index,
                                  got.end_index, got.match_length));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum = '0;
            clear_array();
            expected_results.delete();
            fail_total = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                check_result(res);
            end
            if (cfg_valid && cfg_ready)
            begin
                target_sum = cfg_data;
            end
            if (elem_valid && elem_ready)
            begin
                fold_element(elem);
            end
            failures    <= fail_total;
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- tb/tb_longest_subarray_with_sum_k.sv -----
`timescale 1ns / 100ps

module tb_longest_subarray_with_sum_k;
    import lssk_pkg::*;

    localparam int MAX_ELEMENTS = DEF_MAX_ELEMENTS;
    localparam int ITEM_GOAL    = 1800;
    localparam int HOLD_CYCLES  = 2000;
    localparam logic signed [TARGET_BITS-1:0] TARGET_MAX = {1'b0, {(TARGET_BITS-1){1'b1}}};
    localparam logic signed [TARGET_BITS-1:0] TARGET_MIN = {1'b1, {(TARGET_BITS-1){1'b0}}};

    typedef enum int {
        FILL_SMALL,
        FILL_PLANT,
        FILL_FULL,
        FILL_EDGE,
        FILL_RAIL_LOW,
        FILL_RAIL_HIGH
    } fill_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic signed [TARGET_BITS-1:0] cfg_data;
    logic                          elem_valid;
    logic                          elem_ready;
    elem_word_t                    elem;
    logic                          res_valid;
    logic                          res_ready;
    res_word_t                     res;
    int                            failures;
    int                            outstanding;

    bit tx_quiet;
    bit rx_quiet;
    bit hold_request;
    int items_sent;
    int array_buf [$];

    always #5 clk = ~clk;

    longest_subarray_with_sum_k #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .elem_valid(elem_valid),
        .elem_ready(elem_ready),
        .elem      (elem),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    lssk_checker #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .elem       (elem),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .failures   (failures),
        .outstanding(outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_element(input elem_word_t w);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            elem_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem       <= w;
        elem_valid <= 1'b1;
        do @(posedge clk); while (!elem_ready);
    endtask

    task automatic send_array();
        elem_word_t w;
        foreach (array_buf[n])
        begin
            w.element_value = ELEMENT_BITS'(array_buf[n]);
            w.last_element  = (n == array_buf.size() - 1);
            send_element(w);
            // Only words within the store depth, or the word that ends the array, count as sent.
            if (n < MAX_ELEMENTS || w.last_element)
                items_sent++;
        end
    endtask

    task automatic drain_results();
        elem_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (MAX_ELEMENTS + 8) @(posedge clk);
    endtask

    task automatic write_target(input logic signed [TARGET_BITS-1:0] k);
        drain_results();
        cfg_data  <= k;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_array(input int len, input fill_t fill,
                               input logic signed [TARGET_BITS-1:0] k);
        int a;
        int b;
        int span;
        int rest;
        array_buf = {};
        for (int n = 0; n < len; n++)
        begin
            case (fill)
                FILL_SMALL, FILL_PLANT:
                    array_buf.push_back(int'($urandom_range(0, 16)) - 8);
                FILL_FULL:
                    array_buf.push_back(int'($signed(ELEMENT_BITS'($urandom))));
                FILL_EDGE:
                    case ($urandom_range(0, 4))
                        0:       array_buf.push_back(-32768);
                        1:       array_buf.push_back(32767);
                        2:       array_buf.push_back(0);
                        3:       array_buf.push_back(1);
                        default: array_buf.push_back(-1);
                    endcase
                FILL_RAIL_LOW:
                    array_buf.push_back(-32768);
                default:
                    array_buf.push_back(32767);
            endcase
        end
        // Force one window inside the stored range to sum to the target, when the value it needs fits an element.
        if (fill == FILL_PLANT)
        begin
            span = (len < MAX_ELEMENTS) ? len : MAX_ELEMENTS;
            a    = $urandom_range(0, span - 1);
            b    = $urandom_range(a, span - 1);
            rest = int'(k);
            for (int n = a; n < b; n++)
                rest -= array_buf[n];
            if (rest >= -32768 && rest <= 32767)
                array_buf[b] = rest;
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("** longest_subarray_with_sum_k: FAILED **");
        $finish;
    end

    initial
    begin : result_sink
        int idle_left;
        idle_left = 0;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_quiet)
                res_ready <= 1'b1;
            else if (idle_left > 0)
            begin
                res_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                idle_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int                            phase;
        int                            arrays;
        int                            r;
        int                            len;
        logic signed [TARGET_BITS-1:0] k;
        fill_t                         fill;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        elem_valid   = 1'b0;
        elem         = '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Subarrays from element 0, a tie that keeps the earlier match, no match.
        write_target(23'sd5);
        array_buf = '{2, 3};
        send_array();
        array_buf = '{5, 1, 5};
        send_array();
        array_buf = '{1};
        send_array();

        // Zero-sum search with the element extremes.
        write_target(23'sd0);
        array_buf = '{32767, -32768, 1};
        send_array();
        array_buf = '{3, -3, 0};
        send_array();
        array_buf = '{7};
        send_array();
        array_buf = '{0};
        send_array();

        // Target extremes: differences are compared at full width.
        write_target(TARGET_MAX);
        array_buf = '{-32768, 32767};
        send_array();
        write_target(TARGET_MIN);
        array_buf = '{32767, -32768};
        send_array();

        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                k = '0;
            else if (r < 50)
                k = TARGET_BITS'(int'($urandom_range(0, 40)) - 20);
            else if (r < 62)
                case ($urandom_range(0, 3))
                    0:       k = TARGET_MIN;
                    1:       k = TARGET_MAX;
                    2:       k = -23'sd1;
                    default: k = 23'sd1;
                endcase
            else if (r < 80)
                k = TARGET_BITS'(int'($urandom_range(0, 400000)) - 200000);
            else
                k = TARGET_BITS'($urandom);
            write_target(k);

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            arrays   = $urandom_range(1, 8);
            if (phase == 2)
            begin
                // The result side holds off while short arrays keep coming, so
                // the block ends up holding a result word and stalls its input.
                tx_quiet     = 1'b1;
                hold_request = 1'b1;
                arrays       = 8;
            end

            for (int a = 0; a < arrays; a++)
            begin
                r = $urandom_range(0, 99);
                if (phase == 2)
                    len = $urandom_range(1, 3);
                else if (r < 80)
                    len = $urandom_range(1, 16);
                else if (r < 95)
                    len = $urandom_range(17, 48);
                else if (r < 98)
                    len = $urandom_range(120, MAX_ELEMENTS);
                else
                    len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 12);

                r = $urandom_range(0, 99);
                if (r < 35)
                    fill = FILL_PLANT;
                else if (r < 60)
                    fill = FILL_SMALL;
                else if (r < 80)
                    fill = FILL_FULL;
                else if (r < 92)
                    fill = FILL_EDGE;
                else if (r < 96)
                    fill = FILL_RAIL_LOW;
                else
                    fill = FILL_RAIL_HIGH;

                // A full array of the most negative word reaches the lowest target.
                if (a == 0 && k == TARGET_MIN && phase != 2)
                begin
                    fill = FILL_RAIL_LOW;
                    len  = MAX_ELEMENTS;
                end
                build_array(len, fill, k);
                send_array();
            end
            phase++;
        end

        tx_quiet = 1'b0;
        drain_results();
        if (failures == 0 && outstanding == 0)
            $display("** longest_subarray_with_sum_k: PASSED **");
        else
            $display("** longest_subarray_with_sum_k: FAILED **");
        $finish;
    end

endmodule
